[rtl/lik_pkg.sv]
// Shared types, constants and helpers for the leg inverse kinematics block.
`default_nettype none
package lik_pkg;

	// Field and internal widths
	localparam int AW     = 28;   // internal angle, 1/65536 degree
	localparam int RW     = 16;   // radial reach root bits
	localparam int QB     = 31;   // knee cosine quotient bits (Q1.30 magnitude)
	localparam int DW     = 33;   // knee denominator bits
	localparam int SB     = 31;   // knee sine root bits
	localparam int CW     = 49;   // arctangent unit operand width
	localparam int NLANE  = 4;    // arctangent lanes

	typedef logic signed [15:0]   coord_t;
	typedef logic [15:0]          len_t;
	typedef logic signed [17:0]   reach_t;
	typedef logic signed [31:0]   cos_t;
	typedef logic signed [AW-1:0] ang_t;
	typedef logic signed [16:0]   out_ang_t;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_FEMUR = 2'd0;
	localparam logic [1:0] REG_TIBIA = 2'd1;
	localparam logic [1:0] REG_COXA  = 2'd2;

	localparam len_t FEMUR_RST = 16'd1280;
	localparam len_t TIBIA_RST = 16'd1280;
	localparam len_t COXA_RST  = 16'd512;

	localparam ang_t DEG90  = ang_t'(90 * 65536);
	localparam ang_t DEG180 = ang_t'(180 * 65536);

	localparam logic [QB-1:0]   Q30_ONE = QB'(1) << 30;
	localparam logic [2*SB-1:0] Q60_ONE = (2*SB)'(1) << 60;

	// atan(2^-i) in 1/65536 degree
	localparam logic [21:0] ATAN_TAB [24] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
		22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
		22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
	};

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} tgt_t;

	// Carried alongside the reach root
	typedef struct packed {
		tgt_t        t;
		logic [30:0] xsq;
	} sb_r_t;

	// Carried alongside the knee divider
	typedef struct packed {
		tgt_t   t;
		reach_t u;
		logic   flag;
		logic   cneg;
		logic   cforce;
	} sb_d_t;

	// Carried alongside the knee sine root
	typedef struct packed {
		tgt_t   t;
		reach_t u;
		logic   flag;
		cos_t   c;
	} sb_s_t;

	// Round half up to 1/64 degree and saturate to the output field
	function automatic out_ang_t to_out(ang_t a);
		logic signed [AW:0]   t;
		logic signed [AW-10:0] sh;
		t  = (AW+1)'(a) + (AW+1)'(512);
		sh = (AW-9)'(t >>> 10);
		if (sh > 65535)
			return out_ang_t'(65535);
		else if (sh < -65536)
			return out_ang_t'(-65536);
		else
			return out_ang_t'(sh);
	endfunction

endpackage
`default_nettype wire

[rtl/lik_ifs.sv]
// Channel interfaces: foot target in, servo angles out.
`default_nettype none
interface lik_target_if;
	import lik_pkg::*;
	logic   valid;
	logic   ready;
	coord_t target_x;
	coord_t target_y;
	coord_t target_z;
	modport source(output valid, output target_x, output target_y, output target_z,
		input ready);
	modport sink(input valid, input target_x, input target_y, input target_z,
		output ready);
endinterface

interface lik_angle_if;
	import lik_pkg::*;
	logic     valid;
	logic     ready;
	out_ang_t coxa_angle;
	out_ang_t femur_angle;
	out_ang_t tibia_angle;
	logic     out_of_reach;
	modport source(output valid, output coxa_angle, output femur_angle,
		output tibia_angle, output out_of_reach, input ready);
	modport sink(input valid, input coxa_angle, input femur_angle,
		input tibia_angle, input out_of_reach, output ready);
endinterface
`default_nettype wire

[rtl/lik_isqrt.sv]
// Pipelined floor square root, one root bit per stage.
`default_nettype none
module lik_isqrt #(
	parameter int NB  = 16,
	parameter int SBW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [2*NB-1:0] in_val,
	input  logic [SBW-1:0]  in_sb,
	output logic            out_v,
	output logic [NB-1:0]   out_root,
	output logic [SBW-1:0]  out_sb
);
	logic [2*NB-1:0] rem_s  [0:NB];
	logic [NB-1:0]   root_s [0:NB];
	logic [SBW-1:0]  sb_s   [0:NB];
	logic [NB:0]     v_s;

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[NB-1:0], in_v};
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= in_val;
			root_s[0] <= '0;
			sb_s[0]   <= in_sb;
		end
	end

	// One root bit per stage, most significant first
	for (genvar j = 0; j < NB; j++) begin : g_stg
		localparam int B = NB - 1 - j;
		localparam logic [2*NB:0] ONEB = (2*NB+1)'(1) << (2*B);
		localparam logic [NB-1:0] RBIT = NB'(1) << B;
		logic [2*NB:0] trial;
		logic          ge;
		assign trial = ((2*NB+1)'(root_s[j]) << (B+1)) + ONEB;
		assign ge    = {1'b0, rem_s[j]} >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? rem_s[j] - trial[2*NB-1:0] : rem_s[j];
				root_s[j+1] <= ge ? (root_s[j] | RBIT) : root_s[j];
				sb_s[j+1]   <= sb_s[j];
			end
		end
	end

	assign out_v    = v_s[NB];
	assign out_root = root_s[NB];
	assign out_sb   = sb_s[NB];
endmodule
`default_nettype wire

[rtl/lik_div.sv]
// Pipelined restoring divider: floor(num * 2^(QB-1) / den) for num <= den.
`default_nettype none
module lik_div #(
	parameter int QB  = 31,
	parameter int DW  = 33,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_v,
	input  logic [DW-1:0]  in_num,
	input  logic [DW-1:0]  in_den,
	input  logic [SBW-1:0] in_sb,
	output logic           out_v,
	output logic [QB-1:0]  out_q,
	output logic [SBW-1:0] out_sb
);
	logic [DW:0]    rem_s [0:QB];
	logic [DW-1:0]  den_s [0:QB];
	logic [QB-1:0]  q_s   [0:QB];
	logic [SBW-1:0] sb_s  [0:QB];
	logic [QB:0]    v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[QB-1:0], in_v};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= (DW+1)'(in_num);
			den_s[0] <= in_den;
			q_s[0]   <= '0;
			sb_s[0]  <= in_sb;
		end
	end

	// One quotient bit per stage
	for (genvar j = 0; j < QB; j++) begin : g_stg
		logic          ge;
		logic [DW:0]   diff;
		assign ge   = rem_s[j] >= {1'b0, den_s[j]};
		assign diff = ge ? rem_s[j] - {1'b0, den_s[j]} : rem_s[j];
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= {diff[DW-1:0], 1'b0};
				den_s[j+1] <= den_s[j];
				q_s[j+1]   <= {q_s[j][QB-2:0], ge};
				sb_s[j+1]  <= sb_s[j];
			end
		end
	end

	assign out_v  = v_s[QB];
	assign out_q  = q_s[QB];
	assign out_sb = sb_s[QB];
endmodule
`default_nettype wire

[rtl/lik_cordic.sv]
// Pipelined multi-lane CORDIC vectoring unit giving atan2 in 1/65536 degree.
`default_nettype none
module lik_cordic #(
	parameter int NSTG = 16,
	parameter int W    = 49,
	parameter int NL   = 4,
	parameter int SBW  = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  logic signed [W-1:0] in_y [NL],
	input  logic signed [W-1:0] in_x [NL],
	input  logic [SBW-1:0]      in_sb,
	output logic                out_v,
	output lik_pkg::ang_t       out_ang [NL],
	output logic [SBW-1:0]      out_sb
);
	import lik_pkg::*;

	localparam int IW = W + 2;

	logic signed [IW-1:0] pre_x [NL];
	logic signed [IW-1:0] pre_y [NL];
	logic                 pre_zr [NL];
	logic                 pre_bp [NL];
	logic                 pre_bn [NL];

	logic signed [IW-1:0] x_s  [0:NSTG][NL];
	logic signed [IW-1:0] y_s  [0:NSTG][NL];
	ang_t                 a_s  [0:NSTG][NL];
	logic                 zr_s [0:NSTG][NL];
	logic                 bp_s [0:NSTG][NL];
	logic                 bn_s [0:NSTG][NL];
	logic [SBW-1:0]       sb_s [0:NSTG+1];
	logic [NSTG+1:0]      v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[NSTG:0], in_v};
	end

	// Fold the left half plane onto the right, note the origin
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			pre_x[l]  = IW'(in_x[l]);
			pre_y[l]  = IW'(in_y[l]);
			pre_zr[l] = (pre_x[l] == '0) && (pre_y[l] == '0);
			pre_bp[l] = 1'b0;
			pre_bn[l] = 1'b0;
			if (pre_x[l] < 0) begin
				pre_bp[l] = pre_y[l] >= 0;
				pre_bn[l] = pre_y[l] < 0;
				pre_x[l]  = -pre_x[l];
				pre_y[l]  = -pre_y[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NL; l++) begin
				x_s[0][l]  <= pre_x[l];
				y_s[0][l]  <= pre_y[l];
				a_s[0][l]  <= '0;
				zr_s[0][l] <= pre_zr[l];
				bp_s[0][l] <= pre_bp[l];
				bn_s[0][l] <= pre_bn[l];
			end
			sb_s[0] <= in_sb;
		end
	end

	// Micro-rotations
	for (genvar i = 0; i < NSTG; i++) begin : g_stg
		localparam ang_t TAB = ang_t'(ATAN_TAB[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < NL; l++) begin
					if (y_s[i][l] > 0) begin
						x_s[i+1][l] <= x_s[i][l] + (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] - (x_s[i][l] >>> i);
						a_s[i+1][l] <= a_s[i][l] + TAB;
					end else begin
						x_s[i+1][l] <= x_s[i][l] - (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] + (x_s[i][l] >>> i);
						a_s[i+1][l] <= a_s[i][l] - TAB;
					end
					zr_s[i+1][l] <= zr_s[i][l];
					bp_s[i+1][l] <= bp_s[i][l];
					bn_s[i+1][l] <= bn_s[i][l];
				end
				sb_s[i+1] <= sb_s[i];
			end
		end
	end

	// Add back the half-turn offset; the origin reads as zero
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NL; l++) begin
				if (zr_s[NSTG][l])
					out_ang[l] <= '0;
				else if (bp_s[NSTG][l])
					out_ang[l] <= a_s[NSTG][l] + DEG180;
				else if (bn_s[NSTG][l])
					out_ang[l] <= a_s[NSTG][l] - DEG180;
				else
					out_ang[l] <= a_s[NSTG][l];
			end
			sb_s[NSTG+1] <= sb_s[NSTG];
		end
	end

	assign out_v  = v_s[NSTG+1];
	assign out_sb = sb_s[NSTG+1];
endmodule
`default_nettype wire

[rtl/leg_inverse_kinematics_3dof_top.sv]
// Leg inverse kinematics top level: foot target in, three servo angles out.
// Takes one foot target (Q8.8) per clock and returns coxa, femur and tibia angles in
// 1/64 degree plus an out-of-reach flag for knee cosines that had to be clamped.
// Fully pipelined: a new item can be accepted every cycle, and each result passes
// in order through the reach square root, the knee cosine divider, the knee sine
// square root and the four-lane arctangent unit. The whole pipeline stalls only
// while a finished result sits unaccepted at the output. Segment lengths are to be
// written through the configuration port only while no item is in flight; the block
// itself does not enforce it.
`default_nettype none
module leg_inverse_kinematics_3dof_top #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	lik_target_if.sink         target,
	lik_angle_if.source        result
);
	import lik_pkg::*;

	logic adv;

	// Configuration registers
	len_t femur_len_q, tibia_len_q, coxa_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			femur_len_q <= FEMUR_RST;
			tibia_len_q <= TIBIA_RST;
			coxa_len_q  <= COXA_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FEMUR: femur_len_q <= cfg_data;
				REG_TIBIA: tibia_len_q <= cfg_data;
				REG_COXA:  coxa_len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	tgt_t        tgt_s1, tgt_s2, tgt_s3, tgt_s4, tgt_s5;
	logic [30:0] xsq_s1, ysq_s1, zsq_s1, xsq_s2, xsq_s3;
	reach_t      u_s2, u_s3, u_s4, u_s5;
	logic [31:0] usq_s3, fsq_s3, tsq_s3, ft_s3;
	logic signed [34:0] num_s4;
	logic [DW-1:0]      den_s4;
	logic [QB-1:0]      cmag_s5;
	cos_t               c_s5;
	logic               flag_s5, flag_s9;
	logic [2*SB-1:0]    csq_s6;
	sb_s_t              sb_s6, sb_s7, sb_s8;
	logic [46:0]        ts_s7;
	logic signed [47:0] tc_s7;
	logic [SB-1:0]      s_s7, s_s8;
	logic signed [CW-1:0] kx_s8, ky_s8;
	ang_t               coxa_s9, femur_s9, tibia_s9;
	out_ang_t           coxa_s10, femur_s10, tibia_s10;
	logic               flag_s10;

	// Whole pipeline moves unless a result waits at the output
	assign adv          = !v_s10 || result.ready;
	assign target.ready = adv;

	// Unit connections
	logic [RW-1:0]      r_root;
	logic [$bits(sb_r_t)-1:0] r_sb_raw;
	logic               r_v;
	sb_r_t              r_sb;
	logic signed [34:0] num_abs;
	logic [DW-1:0]      d_mag;
	sb_d_t              d_in;
	logic [QB-1:0]      d_q;
	logic [$bits(sb_d_t)-1:0] d_sb_raw;
	logic               d_v;
	sb_d_t              d_sb;
	logic [SB-1:0]      s_root;
	logic [$bits(sb_s_t)-1:0] s_sb_raw;
	logic               s_v;
	sb_s_t              s_sb;
	logic signed [CW-1:0] lane_y [NLANE];
	logic signed [CW-1:0] lane_x [NLANE];
	ang_t               lane_ang [NLANE];
	logic               k_flag;
	logic               k_v;
	logic [QB-1:0]      cmag_d;
	ang_t               femur_d;
	logic signed [31:0] sx, sy, sz;

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
			{v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
		end else if (adv) begin
			v_s1  <= target.valid;
			v_s2  <= r_v;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= d_v;
			v_s6  <= v_s5;
			v_s7  <= s_v;
			v_s8  <= v_s7;
			v_s9  <= k_v;
			v_s10 <= v_s9;
		end
	end

	// Stage 1: capture target, square coordinates
	assign sx = 32'(target.target_x);
	assign sy = 32'(target.target_y);
	assign sz = 32'(target.target_z);

	always_ff @(posedge clk) begin
		if (adv) begin
			tgt_s1 <= '{x: target.target_x, y: target.target_y, z: target.target_z};
			xsq_s1 <= 31'(sx * sx);
			ysq_s1 <= 31'(sy * sy);
			zsq_s1 <= 31'(sz * sz);
		end
	end

	// Radial reach r = floor(sqrt(y^2 + z^2))
	lik_isqrt #(.NB(RW), .SBW($bits(sb_r_t))) u_sqrt_r (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_v(v_s1),
		.in_val(32'(ysq_s1) + 32'(zsq_s1)),
		.in_sb(sb_r_t'{t: tgt_s1, xsq: xsq_s1}),
		.out_v(r_v), .out_root(r_root), .out_sb(r_sb_raw)
	);
	assign r_sb = sb_r_t'(r_sb_raw);

	// Stages 2 to 4: reach past the hip, knee cosine numerator and denominator
	always_ff @(posedge clk) begin
		if (adv) begin
			u_s2   <= $signed({2'b00, r_root}) - $signed({2'b00, coxa_len_q});
			tgt_s2 <= r_sb.t;
			xsq_s2 <= r_sb.xsq;

			usq_s3 <= 32'(34'(u_s2) * 34'(u_s2));
			fsq_s3 <= 32'(femur_len_q) * 32'(femur_len_q);
			tsq_s3 <= 32'(tibia_len_q) * 32'(tibia_len_q);
			ft_s3  <= 32'(femur_len_q) * 32'(tibia_len_q);
			u_s3   <= u_s2;
			tgt_s3 <= tgt_s2;
			xsq_s3 <= xsq_s2;

			num_s4 <= $signed(35'(xsq_s3)) + $signed(35'(usq_s3))
				- $signed(35'(fsq_s3)) - $signed(35'(tsq_s3));
			den_s4 <= {ft_s3, 1'b0};
			u_s4   <= u_s3;
			tgt_s4 <= tgt_s3;
		end
	end

	// Clamp decision ahead of the divider
	assign num_abs = (num_s4 < 0) ? -num_s4 : num_s4;

	always_comb begin
		d_in.t      = tgt_s4;
		d_in.u      = u_s4;
		d_in.flag   = 1'b0;
		d_in.cneg   = num_s4 < 0;
		d_in.cforce = 1'b0;
		d_mag       = num_abs[DW-1:0];
		priority if (den_s4 == '0) begin
			d_in.flag   = 1'b1;
			d_in.cforce = 1'b1;
			d_in.cneg   = 1'b0;
		end else if (num_s4 > $signed(35'(den_s4))) begin
			d_in.flag   = 1'b1;
			d_in.cforce = 1'b1;
			d_in.cneg   = 1'b0;
		end else if (num_s4 < -$signed(35'(den_s4))) begin
			d_in.flag   = 1'b1;
			d_in.cforce = 1'b1;
			d_in.cneg   = 1'b1;
		end
		if (d_in.cforce)
			d_mag = '0;
	end

	lik_div #(.QB(QB), .DW(DW), .SBW($bits(sb_d_t))) u_div (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_v(v_s4),
		.in_num(d_mag), .in_den(den_s4), .in_sb(d_in),
		.out_v(d_v), .out_q(d_q), .out_sb(d_sb_raw)
	);
	assign d_sb = sb_d_t'(d_sb_raw);

	// Stages 5 and 6: signed cosine, then its square
	assign cmag_d = d_sb.cforce ? Q30_ONE : d_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmag_s5 <= cmag_d;
			c_s5    <= d_sb.cneg ? -$signed(32'(cmag_d)) : $signed(32'(cmag_d));
			u_s5    <= d_sb.u;
			tgt_s5  <= d_sb.t;
			flag_s5 <= d_sb.flag;

			csq_s6  <= (2*SB)'(cmag_s5) * (2*SB)'(cmag_s5);
			sb_s6   <= '{t: tgt_s5, u: u_s5, flag: flag_s5, c: c_s5};
		end
	end

	// Knee sine s = floor(sqrt(2^60 - c^2))
	lik_isqrt #(.NB(SB), .SBW($bits(sb_s_t))) u_sqrt_s (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_v(v_s6),
		.in_val(Q60_ONE - csq_s6), .in_sb(sb_s6),
		.out_v(s_v), .out_root(s_root), .out_sb(s_sb_raw)
	);
	assign s_sb = sb_s_t'(s_sb_raw);

	// Stages 7 and 8: knee triangle vector (T*s, F + T*c)
	always_ff @(posedge clk) begin
		if (adv) begin
			ts_s7 <= 47'(tibia_len_q) * 47'(s_root);
			tc_s7 <= $signed(48'(tibia_len_q)) * 48'(s_sb.c);
			s_s7  <= s_root;
			sb_s7 <= s_sb;

			kx_s8 <= $signed(CW'({femur_len_q, 30'b0})) + CW'(tc_s7);
			ky_s8 <= $signed(CW'(ts_s7));
			s_s8  <= s_s7;
			sb_s8 <= sb_s7;
		end
	end

	// Arctangent lanes: coxa, hip, knee phase, knee offset
	assign lane_y[0] = CW'($signed({sb_s8.t.z, 16'b0}));
	assign lane_x[0] = CW'($signed({sb_s8.t.y, 16'b0}));
	assign lane_y[1] = CW'($signed({sb_s8.u, 16'b0}));
	assign lane_x[1] = CW'($signed({sb_s8.t.x, 16'b0}));
	assign lane_y[2] = $signed(CW'(s_s8));
	assign lane_x[2] = CW'(sb_s8.c);
	assign lane_y[3] = ky_s8;
	assign lane_x[3] = kx_s8;

	lik_cordic #(.NSTG(CORDIC_STAGES), .W(CW), .NL(NLANE), .SBW(1)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_v(v_s8),
		.in_y(lane_y), .in_x(lane_x), .in_sb(sb_s8.flag),
		.out_v(k_v), .out_ang(lane_ang), .out_sb(k_flag)
	);

	// Stage 9: joint angles; stage 10: round and saturate into the output register
	assign femur_d = DEG90 + lane_ang[1] - lane_ang[3];

	always_ff @(posedge clk) begin
		if (adv) begin
			coxa_s9   <= DEG90 + lane_ang[0];
			femur_s9  <= femur_d;
			tibia_s9  <= DEG90 + DEG180 - lane_ang[2] - femur_d;
			flag_s9   <= k_flag;

			coxa_s10  <= to_out(coxa_s9);
			femur_s10 <= to_out(femur_s9);
			tibia_s10 <= to_out(tibia_s9);
			flag_s10  <= flag_s9;
		end
	end

	assign result.valid        = v_s10;
	assign result.coxa_angle   = coxa_s10;
	assign result.femur_angle  = femur_s10;
	assign result.tibia_angle  = tibia_s10;
	assign result.out_of_reach = flag_s10;
endmodule
`default_nettype wire

[tb/sv/lik_angle_checker.sv]
// Angle checker: predicts servo angles from watched targets and compares results.
`default_nettype none
module lik_angle_checker #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	lik_target_if       tgt_mon,
	lik_angle_if        res_mon,
	output int          errors,
	output int          pending
);
	import lik_pkg::*;

	localparam longint ARC90  = longint'(90) * 65536;
	localparam longint ARC180 = longint'(180) * 65536;
	localparam longint UNIT30 = longint'(1) << 30;

	typedef struct {
		out_ang_t coxa;
		out_ang_t femur;
		out_ang_t tibia;
		logic     reach_flag;
	} angles_t;

	angles_t angle_queue[$];
	len_t    femur_len, tibia_len, coxa_len;
	int      mismatches;

	assign errors = mismatches;

	// integer square root, floor
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// vectoring arctangent in 1/65536 degree
	function automatic longint arctan_deg(longint yy, longint xx);
		longint base, acc, dx, dy;
		base = 0;
		acc  = 0;
		if (xx == 0 && yy == 0) return 0;
		if (xx < 0) begin
			base = (yy >= 0) ? ARC180 : -ARC180;
			xx = -xx;
			yy = -yy;
		end
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			dx = yy >>> i;
			dy = xx >>> i;
			if (yy > 0) begin
				xx += dx;
				yy -= dy;
				acc += longint'(ATAN_TAB[i]);
			end else begin
				xx -= dx;
				yy += dy;
				acc -= longint'(ATAN_TAB[i]);
			end
		end
		return base + acc;
	endfunction

	// round half up to 1/64 degree, saturate
	function automatic out_ang_t servo_units(longint a);
		longint r;
		r = (a + 512) >>> 10;
		if (r > 65535) r = 65535;
		if (r < -65536) r = -65536;
		return out_ang_t'(r);
	endfunction

	function automatic angles_t solve_leg(coord_t tx, coord_t ty, coord_t tz);
		longint x, y, z, lf, lt, lc, r, u, num, den, c, s, phi, hip, femur;
		longint unsigned mag;
		angles_t a;
		x  = tx;
		y  = ty;
		z  = tz;
		lf = femur_len;
		lt = tibia_len;
		lc = coxa_len;
		a.reach_flag = 1'b0;
		r = longint'(floor_sqrt(longint'(y * y + z * z)));
		u = r - lc;
		a.coxa = servo_units(ARC90 + arctan_deg(z * 65536, y * 65536));
		// knee cosine, clamped
		num = x * x + u * u - lf * lf - lt * lt;
		den = 2 * lf * lt;
		if (den == 0 || num > den) begin
			c = UNIT30;
			a.reach_flag = 1'b1;
		end else if (num < -den) begin
			c = -UNIT30;
			a.reach_flag = 1'b1;
		end else begin
			mag = (num < 0) ? -num : num;
			c = longint'((mag << 30) / longint'(den));
			if (num < 0) c = -c;
		end
		s = longint'(floor_sqrt(UNIT30 * UNIT30 - c * c));
		phi = arctan_deg(s, c);
		hip = arctan_deg(u * 65536, x * 65536) - arctan_deg(lt * s, lf * UNIT30 + lt * c);
		femur = ARC90 + hip;
		a.femur = servo_units(femur);
		a.tibia = servo_units(ARC90 + (ARC180 - phi) - femur);
		return a;
	endfunction

	// segment length registers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			femur_len <= FEMUR_RST;
			tibia_len <= TIBIA_RST;
			coxa_len  <= COXA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FEMUR: femur_len <= cfg_data;
				REG_TIBIA: tibia_len <= cfg_data;
				REG_COXA:  coxa_len  <= cfg_data;
				default: ;
			endcase
		end
	end

	// predict on accepted targets, compare accepted results
	always @(posedge clk) begin
		angles_t want;
		if (arst_n) begin
			if (tgt_mon.valid && tgt_mon.ready)
				angle_queue.push_back(solve_leg(tgt_mon.target_x, tgt_mon.target_y,
					tgt_mon.target_z));
			if (res_mon.valid && res_mon.ready) begin
				if (angle_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: result with no item pending at %0t", $realtime);
				end else begin
					want = angle_queue.pop_front();
					if (res_mon.coxa_angle !== want.coxa || res_mon.femur_angle !== want.femur ||
						res_mon.tibia_angle !== want.tibia ||
						res_mon.out_of_reach !== want.reach_flag) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: exp coxa %0d femur %0d tibia %0d reach %0b, got %0d %0d %0d %0b",
								want.coxa, want.femur, want.tibia, want.reach_flag,
								res_mon.coxa_angle, res_mon.femur_angle,
								res_mon.tibia_angle, res_mon.out_of_reach);
					end
				end
			end
		end
		pending = angle_queue.size();
	end

	initial begin
		mismatches = 0;
		pending    = 0;
	end
endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Testbench top: drives targets and segment lengths, gives the verdict.
`default_nettype none
module tb;
	import lik_pkg::*;

	localparam int          STAGES     = 16;
	localparam int          PHASES     = 8;
	localparam int          PHASE_ITEMS = 106;
	localparam int          HOLD_CYCLES = 400;
	localparam int          DRAIN_CYCLES = 150;
	localparam int          CYCLE_LIMIT = 600000;
	localparam logic [1:0]  REG_NONE   = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          errors, pending, cycles;
	int          send_idle, recv_stall;
	bit          hold_req;

	lik_target_if tgt();
	lik_angle_if  res();

	leg_inverse_kinematics_3dof_top #(.CORDIC_STAGES(STAGES)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .target(tgt), .result(res)
	);

	lik_angle_checker #(.CORDIC_STAGES(STAGES)) u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .tgt_mon(tgt), .res_mon(res), .errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("** leg_inverse_kinematics_3dof_top: FAILED **");
				$finish;
			end
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res.ready <= arst_n && ($urandom_range(99) >= recv_stall);
		end
	end

	// offer one item, return at the edge where it is taken
	task automatic send_target(coord_t x, coord_t y, coord_t z);
		logic took;
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			tgt.valid <= 1'b0;
			@(posedge clk);
		end
		tgt.valid    <= 1'b1;
		tgt.target_x <= x;
		tgt.target_y <= y;
		tgt.target_z <= z;
		do begin
			@(negedge clk);
			took = tgt.ready;
			@(posedge clk);
		end while (!took);
	endtask

	// write all three lengths; strobe lowered once at the end
	task automatic set_lengths(len_t f, len_t t, len_t c);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FEMUR;
		cfg_data  <= f;
		@(posedge clk);
		cfg_index <= REG_TIBIA;
		cfg_data  <= t;
		@(posedge clk);
		cfg_index <= REG_COXA;
		cfg_data  <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// step past the current edge first so the last accepted item is already counted
	task automatic wait_drained();
		tgt.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly targets within the leg's span, some anywhere in the field
	function automatic coord_t pick_coord(int span, int kind);
		if (kind < 70)
			return coord_t'($signed($urandom_range(2 * span)) - span);
		else if (kind < 85)
			return coord_t'($urandom);
		else
			return (kind < 92) ? coord_t'(0) : coord_t'($urandom_range(1) ? 16'h7fff : 16'h8000);
	endfunction

	initial begin
		int span, kind;
		len_t f, t, c;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_FEMUR;
		cfg_data     = '0;
		tgt.valid    = 1'b0;
		tgt.target_x = '0;
		tgt.target_y = '0;
		tgt.target_z = '0;
		send_idle    = 0;
		recv_stall   = 0;
		hold_req     = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: origin, field extremes, axis cases, exact knee limits
		send_target(0, 0, 0);
		send_target(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_target(-16'sh8000, -16'sh8000, -16'sh8000);
		send_target(-16'sh8000, 0, 0);
		send_target(0, -256, 0);
		send_target(-500, 512, 0);
		send_target(0, 512, 0);
		send_target(0, 3072, 0);
		send_target(1280, 1792, 0);
		send_target(0, 0, 256);
		send_target(0, 0, -256);
		send_target(-16'sh8000, 16'sh7fff, -16'sh8000);
		send_target(300, -1200, 900);
		send_target(-1, -1, -1);
		send_target(1, 1, 1);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin f = FEMUR_RST; t = TIBIA_RST; c = COXA_RST; end
				1: begin f = 16'hffff; t = 16'hffff; c = 16'hffff; end
				2: begin f = 16'd1; t = 16'd1; c = 16'd0; end
				3: begin f = 16'd0; t = 16'd1280; c = 16'd512; end
				4: begin f = 16'd1280; t = 16'd0; c = 16'd0; end
				6: begin f = 16'hffff; t = 16'd1; c = 16'd0; end
				default: begin
					f = len_t'($urandom_range(4000, 1));
					t = len_t'($urandom_range(4000, 1));
					c = len_t'($urandom_range(2000));
				end
			endcase
			if (p != 0) set_lengths(f, t, c);
			// unused index must be ignored
			if (p == 5) begin
				cfg_we    <= 1'b1;
				cfg_index <= REG_NONE;
				cfg_data  <= 16'h1234;
				@(posedge clk);
				cfg_we <= 1'b0;
			end
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 71; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 71; end
				default: begin send_idle = 16; recv_stall = 16; end
			endcase
			span = int'(f) + int'(t) + int'(c);
			if (span > 32767) span = 32767;
			if (span < 64) span = 64;
			if (p == 0) hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				kind = $urandom_range(99);
				send_target(pick_coord(span / 2, kind), pick_coord(span, kind),
					pick_coord(span, kind));
				// sender pause until every result is back
				if (p == 2 && i == PHASE_ITEMS / 2) wait_drained();
			end
			wait_drained();
		end

		if (errors == 0 && pending == 0)
			$display("** leg_inverse_kinematics_3dof_top: PASSED **");
		else
			$display("** leg_inverse_kinematics_3dof_top: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
rtl/lik_pkg.sv
rtl/lik_ifs.sv
rtl/lik_isqrt.sv
rtl/lik_div.sv
rtl/lik_cordic.sv
rtl/leg_inverse_kinematics_3dof_top.sv
tb/sv/lik_angle_checker.sv
tb/sv/tb.sv
